@@ design/tsk_pkg.sv @@
// package for the triple sha-1 key check block
// holds sha-1 constants, the fixed key and round helper functions; no dependencies
package tsk_pkg;

  localparam int unsigned NumRounds = 80;

  // register indexes of the write port
  typedef enum logic [1:0] {
    REG_HEAD   = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_TAIL   = 2'd2
  } cfg_reg_e;

  // fixed 16-byte key as four big-endian words
  localparam logic [31:0] Key0 = 32'h77214d4b;
  localparam logic [31:0] Key1 = 32'h196a87cd;
  localparam logic [31:0] Key2 = 32'h520045fd;
  localparam logic [31:0] Key3 = 32'h20a51d67;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  typedef logic [159:0] digest_t;
  typedef logic [511:0] block_t;

  // working variables a..e packed as {a,b,c,d,e}
  typedef logic [159:0] abcde_t;

  // one sha-1 round, round index is constant per stage
  function automatic abcde_t sha1_round(input abcde_t s, input logic [31:0] w,
                                        input int unsigned idx);
    logic [31:0] a, b, c, d, e, f, k, t;
    a = s[159:128]; b = s[127:96]; c = s[95:64]; d = s[63:32]; e = s[31:0];
    if (idx < 20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (idx < 40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (idx < 60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w;
    return {t, a, {b[1:0], b[31:2]}, c, d};
  endfunction

  // next schedule window: drop w[0], append new word
  function automatic block_t sched_next(input block_t win);
    logic [31:0] nw, x;
    x = win[95:64] ^ win[255:224] ^ win[447:416] ^ win[511:480];
    nw = {x[30:0], x[31]};
    return {win[479:0], nw};
  endfunction

endpackage

@@ design/triple_sha1_key_check_top.sv @@
// top level of the triple sha-1 key check
// depends on tsk_pkg and tsk_sha1_pipe; holds the target registers and compare
//
// Takes one candidate per cycle, every cycle, with no stall: busy is always
// low. Each candidate runs through three 80-stage sha-1 pipelines plus a compare
// register, and its result appears with done_o out of that compare register,
// in the order accepted. Results cannot be held off: sample candidate_out_o
// and match_o while done_o is high. Write the target only while no candidate
// is in flight.
module triple_sha1_key_check_top import tsk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] candidate_i,
  output logic        done_o,
  output logic [31:0] candidate_out_o,
  output logic        match_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]  head_q, middle_q;
  logic [31:0]  tail_q;
  logic [31:0]  cb;
  logic         v1, v2, v3;
  digest_t      h1, h2, h3, h1b;
  logic [31:0]  t1, t2, t3;
  logic [191:0] tg2;
  block_t       b1, b2, b3;
  logic         done_q, match_q;
  logic [31:0]  cand_q;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; middle_q <= '0; tail_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAD:   head_q   <= cfg_data_i;
        REG_MIDDLE: middle_q <= cfg_data_i;
        REG_TAIL:   tail_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // candidate bytes little endian
  assign cb = {candidate_i[7:0], candidate_i[15:8], candidate_i[23:16], candidate_i[31:24]};
  assign b1 = {Key0, Key1, Key2, Key3, cb, 32'h80000000, 256'd0, 64'd160};

  tsk_sha1_pipe #(.TagW(32)) u_h1 (
    .clk_i, .rst_ni, .valid_i(start), .block_i(b1), .tag_i(candidate_i),
    .valid_o(v1), .digest_o(h1), .tag_o(t1)
  );

  assign b2 = {Key0, Key1, Key2, Key3, h1,
               t1[7:0], t1[15:8], t1[23:16], t1[31:24],
               32'h80000000, 96'd0, 64'd320};

  // second hash carries h1 along with the candidate
  tsk_sha1_pipe #(.TagW(192)) u_h2 (
    .clk_i, .rst_ni, .valid_i(v1), .block_i(b2), .tag_i({h1, t1}),
    .valid_o(v2), .digest_o(h2), .tag_o(tg2)
  );

  assign h1b = tg2[191:32];
  assign t2  = tg2[31:0];

  assign b3 = {h1b[159:32], h2[159:32], 32'h80000000, 160'd0, 64'd256};

  tsk_sha1_pipe #(.TagW(32)) u_h3 (
    .clk_i, .rst_ni, .valid_i(v2), .block_i(b3), .tag_i(t2),
    .valid_o(v3), .digest_o(h3), .tag_o(t3)
  );

  // compare and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v3;
    end
  end
  always_ff @(posedge clk_i) begin
    cand_q  <= t3;
    match_q <= (h3 == {head_q, middle_q, tail_q});
  end

  assign done_o          = done_q;
  assign candidate_out_o = cand_q;
  assign match_o         = match_q;

`ifndef SYNTH
  // a result follows every start transfer after the full latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##241 done_o) else $error("result missing");
  // never a result without a start transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(start, 241)) else $error("spurious result");
  // the tag travels intact through all three hashes
  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##241 (candidate_out_o == $past(candidate_i, 241)))
    else $error("candidate corrupted");
`endif

endmodule

@@ design/tsk_sha1_pipe.sv @@
// fully pipelined single-block sha-1, one round per register stage
// depends on tsk_pkg; carries a tag of TagW bits alongside each block
module tsk_sha1_pipe import tsk_pkg::*; #(
  parameter int unsigned TagW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  block_t          block_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output digest_t         digest_o,
  output logic [TagW-1:0] tag_o
);

  logic [NumRounds-1:0] vld_q;
  abcde_t          st_q  [NumRounds];
  block_t          win_q [NumRounds];
  logic [TagW-1:0] tag_q [NumRounds];

  // round stages
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    logic            vld_in;
    abcde_t          st_in;
    block_t          win_in;
    logic [TagW-1:0] tag_in;

    // first round takes the block port, the others the previous stage
    if (r == 0) begin : g_first
      assign vld_in = valid_i;
      assign st_in  = {Iv0, Iv1, Iv2, Iv3, Iv4};
      assign win_in = block_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[r-1];
      assign st_in  = st_q[r-1];
      assign win_in = win_q[r-1];
      assign tag_in = tag_q[r-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r] <= 1'b0;
      end else begin
        vld_q[r] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[r]  <= sha1_round(st_in, win_in[511:480], r);
      win_q[r] <= sched_next(win_in);
      tag_q[r] <= tag_in;
    end
  end

  // final feed-forward add
  assign digest_o = {st_q[NumRounds-1][159:128] + Iv0, st_q[NumRounds-1][127:96] + Iv1,
                     st_q[NumRounds-1][95:64] + Iv2, st_q[NumRounds-1][63:32] + Iv3,
                     st_q[NumRounds-1][31:0] + Iv4};
  assign valid_o  = vld_q[NumRounds-1];
  assign tag_o    = tag_q[NumRounds-1];

endmodule
